FILE: rtl/hcwt_pkg.sv
// Package for the hit-count window trigger.
// Holds shared constants, register indexes and the word types passed between modules.
// No dependencies.
package hcwt_pkg;

  localparam int NUM_SENSORS_DEF    = 4096;
  localparam int MAX_PULSE_BINS_DEF = 64;
  localparam int TIME_BITS_DEF      = 32;

  localparam int COUNT_W = 16;
  localparam int SUM_W   = 22;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    REG_LOCKOUT,
    REG_WIDTH,
    REG_THRESHOLD,
    REG_HOLDOFF
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_SKIP,
    CMD_HIT,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [11:0] sensor_id;
    logic [31:0] hit_time;
  } cmd_t;

  typedef struct packed {
    logic [15:0]      lockout;
    logic [6:0]       win_bins;
    logic [SUM_W-1:0] threshold;
    logic [15:0]      holdoff;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] window_sum;
    logic [31:0]      trigger_bin;
  } res_t;

endpackage

FILE: rtl/hcwt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when the same address is written in that cycle.
// No dependencies.
module hcwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hcwt_fifo.sv
// Small flop-based FIFO used for the command queue and the result queue.
// No dependencies.
module hcwt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

FILE: rtl/hcwt_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on hcwt_pkg and hcwt_fifo.
module hcwt_front import hcwt_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [11:0] sensor_id, [43:12] hit_time
  input  logic        in_tuser,   // [0] opcode
  input  logic        clearing,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam int QCW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t           in_cmd;
  logic           in_range;
  logic           push;
  logic           full;
  logic           empty;
  logic [QCW-1:0] qcount;

  always_comb begin
    in_range         = (32'(in_tdata[11:0]) < 32'(NUM_SENSORS));
    in_cmd.sensor_id = in_tdata[11:0];
    in_cmd.hit_time  = in_tdata[43:12];
    if (in_tuser) begin
      in_cmd.kind = CMD_TICK;
    end else if (in_range) begin
      in_cmd.kind = CMD_HIT;
    end else begin
      in_cmd.kind = CMD_SKIP;
    end
  end

  assign full      = (qcount == QCW'(CMD_FIFO_DEPTH));
  assign in_tready = !clearing && !full;
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = !empty;

  hcwt_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_cmd),
    .pop   (cmd_valid && cmd_ready),
    .rdata (cmd),
    .empty (empty),
    .count (qcount)
  );

endmodule

FILE: rtl/hcwt_back.sv
// Back end: sensor lockout read-modify-write, bin closing, window sum and trigger decision.
// Depends on hcwt_pkg, hcwt_ram and hcwt_fifo.
module hcwt_back import hcwt_pkg::*; #(
  parameter int NUM_SENSORS    = NUM_SENSORS_DEF,
  parameter int MAX_PULSE_BINS = MAX_PULSE_BINS_DEF,
  parameter int TIME_BITS      = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic clearing,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int SW  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int HW  = (MAX_PULSE_BINS > 1) ? $clog2(MAX_PULSE_BINS) : 1;
  localparam int WW  = $clog2(MAX_PULSE_BINS + 1);
  localparam int PW  = COUNT_W + WW;
  localparam int TB  = TIME_BITS;
  localparam int OCW = $clog2(OUT_FIFO_DEPTH + 1);

  logic          clr_r;
  logic [SW-1:0] clr_cnt_r;

  logic          pop;
  logic [15:0]   wid16;
  logic [WW-1:0] wid;
  logic [WW-1:0] fill_r, fill_nxt;
  logic [HW-1:0] slot_r, slot_nxt;
  logic [WW:0]   slot_ext, wid_ext, hraddr_raw;
  logic [HW-1:0] hraddr;
  logic [31:0]   id_ext;
  logic [SW-1:0] saddr_pop;

  logic          b_v_r;
  cmd_kind_e     b_kind_r;
  logic [SW-1:0] b_saddr_r;
  logic [TB-1:0] b_time_r;
  logic [HW-1:0] b_hslot_r;
  logic [HW-1:0] b_hraddr_r;
  logic          b_hok_r;
  logic          b_wzero_r;

  logic          s_we;
  logic [SW-1:0] s_waddr;
  logic [TB:0]   s_wdata, s_rdata;
  logic [PW-1:0] h_rdata;

  logic          sfw_v_r;
  logic [SW-1:0] sfw_addr_r;
  logic [TB:0]   sfw_data_r;
  logic          hfw_v_r;
  logic [HW-1:0] hfw_addr_r;
  logic [PW-1:0] hfw_data_r;

  logic [COUNT_W-1:0] cur_r, cur_nxt;
  logic [PW-1:0]      tot_r, tot_nxt;
  logic [31:0]        bin_r, bin_nxt;
  logic [31:0]        ltrig_r, ltrig_nxt;
  logic               tseen_r, tseen_nxt;

  logic [TB:0]      s_entry;
  logic             seen;
  logic [TB-1:0]    last;
  logic             is_hit, is_tick, hit_count;
  logic [PW-1:0]    h_entry, prev, p_new, diff;
  logic [31:0]      sum_ext;
  logic [SUM_W-1:0] win_sum;
  logic             fire;
  logic [OCW-1:0]   ocount;
  logic             oempty;

  // Sensor memory clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == SW'(NUM_SENSORS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign clearing  = clr_r;
  assign cmd_ready = !clr_r &&
                     ((OCW + 1)'(ocount) + (OCW + 1)'(b_v_r) < (OCW + 1)'(OUT_FIFO_DEPTH));
  assign pop       = cmd_valid && cmd_ready;

  // Issue: memory reads and history slot bookkeeping.
  always_comb begin
    wid16 = (16'(cfg.win_bins) > 16'(MAX_PULSE_BINS)) ?
            16'(MAX_PULSE_BINS) : 16'(cfg.win_bins);
    wid        = WW'(wid16);
    slot_ext   = (WW + 1)'(slot_r);
    wid_ext    = (WW + 1)'(wid);
    hraddr_raw = (slot_ext >= wid_ext) ? slot_ext - wid_ext :
                 slot_ext + (WW + 1)'(MAX_PULSE_BINS) - wid_ext;
    hraddr     = hraddr_raw[HW-1:0];
    id_ext     = 32'(cmd.sensor_id);
    saddr_pop  = id_ext[SW-1:0];
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    if (pop && (cmd.kind == CMD_TICK)) begin
      slot_nxt = (slot_r == HW'(MAX_PULSE_BINS - 1)) ? '0 : slot_r + 1'b1;
      fill_nxt = (fill_r == WW'(MAX_PULSE_BINS)) ? fill_r : fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r  <= 1'b0;
      slot_r <= '0;
      fill_r <= '0;
    end else begin
      b_v_r  <= pop;
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_kind_r   <= cmd.kind;
      b_saddr_r  <= saddr_pop;
      b_time_r   <= TB'(cmd.hit_time);
      b_hslot_r  <= slot_r;
      b_hraddr_r <= hraddr;
      b_hok_r    <= (fill_r >= wid) && (wid != '0);
      b_wzero_r  <= (wid == '0);
    end
  end

  // Execute: one hit or one bin tick per cycle while commands issue, forwarding last cycle's writes.
  always_comb begin
    is_hit  = b_v_r && (b_kind_r == CMD_HIT);
    is_tick = b_v_r && (b_kind_r == CMD_TICK);

    s_entry   = (sfw_v_r && (sfw_addr_r == b_saddr_r)) ? sfw_data_r : s_rdata;
    seen      = s_entry[TB];
    last      = s_entry[TB-1:0];
    hit_count = !seen || ((b_time_r > last) && ((b_time_r - last) > TB'(cfg.lockout)));

    h_entry = (hfw_v_r && (hfw_addr_r == b_hraddr_r)) ? hfw_data_r : h_rdata;
    prev    = b_hok_r ? h_entry : '0;
    p_new   = tot_r + PW'(cur_r);
    diff    = p_new - prev;
    sum_ext = 32'(diff);
    if (b_wzero_r) begin
      win_sum = '0;
    end else if (sum_ext > 32'(SUM_MAX)) begin
      win_sum = SUM_MAX;
    end else begin
      win_sum = sum_ext[SUM_W-1:0];
    end
    fire = is_tick && (win_sum >= cfg.threshold) &&
           (!tseen_r || ((bin_r - ltrig_r) > 32'(cfg.holdoff)));

    s_we    = clr_r || (is_hit && hit_count);
    s_waddr = clr_r ? clr_cnt_r : b_saddr_r;
    s_wdata = clr_r ? '0 : {1'b1, b_time_r};

    cur_nxt   = cur_r;
    tot_nxt   = tot_r;
    bin_nxt   = bin_r;
    ltrig_nxt = ltrig_r;
    tseen_nxt = tseen_r;
    if (is_tick) begin
      cur_nxt = '0;
      tot_nxt = p_new;
      bin_nxt = bin_r + 1'b1;
    end else if (is_hit && hit_count && (cur_r != COUNT_MAX)) begin
      cur_nxt = cur_r + 1'b1;
    end
    if (fire) begin
      ltrig_nxt = bin_r;
      tseen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      tot_r   <= '0;
      bin_r   <= '0;
      ltrig_r <= '0;
      tseen_r <= 1'b0;
      sfw_v_r <= 1'b0;
      hfw_v_r <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      tot_r   <= tot_nxt;
      bin_r   <= bin_nxt;
      ltrig_r <= ltrig_nxt;
      tseen_r <= tseen_nxt;
      sfw_v_r <= is_hit && hit_count;
      hfw_v_r <= is_tick;
    end
  end

  always_ff @(posedge clk) begin
    sfw_addr_r <= b_saddr_r;
    sfw_data_r <= {1'b1, b_time_r};
    hfw_addr_r <= b_hslot_r;
    hfw_data_r <= p_new;
  end

  hcwt_ram #(
    .WIDTH(TB + 1),
    .DEPTH(NUM_SENSORS)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (saddr_pop),
    .rdata (s_rdata)
  );

  // Running total of closed bin counts, one entry per bin slot.
  hcwt_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_PULSE_BINS)
  ) u_total_ram (
    .clk   (clk),
    .we    (is_tick),
    .waddr (b_hslot_r),
    .wdata (p_new),
    .raddr (hraddr),
    .rdata (h_rdata)
  );

  hcwt_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .wdata ({win_sum, bin_r}),
    .pop   (res_valid && res_ready),
    .rdata (res),
    .empty (oempty),
    .count (ocount)
  );

  assign res_valid = !oempty;

endmodule

FILE: rtl/hit_count_window_trigger_unit.sv
// Hit-count window trigger, top level: configuration registers, front end and back end.
// Sustains one word per cycle while in_tready is high; the sensor memory is read at issue and written the next cycle.
// A trigger word passes the command queue, the issue registers and the result queue to out_tvalid.
// Reset is synchronous; afterwards a pass over all NUM_SENSORS entries clears the sensor memory,
// with in_tready low, and registers return to lockout 0, width 1, threshold 1, holdoff 0.
module hit_count_window_trigger_unit import hcwt_pkg::*; #(
  parameter int NUM_SENSORS    = NUM_SENSORS_DEF,
  parameter int MAX_PULSE_BINS = MAX_PULSE_BINS_DEF,
  parameter int TIME_BITS      = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [11:0] sensor_id, [43:12] hit_time
  input  logic        in_tuser,    // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [31:0] trigger_bin, [53:32] window_sum
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0]      lockout_r;
  logic [6:0]       width_r;
  logic [SUM_W-1:0] thresh_r;
  logic [15:0]      holdoff_r;
  logic             wr_en;
  cfg_t             cfg;
  logic             clearing;
  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  res_t             res;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= '0;
      width_r   <= 7'd1;
      thresh_r  <= SUM_W'(1);
      holdoff_r <= '0;
    end else if (wr_en) begin
      case (reg_idx_e'(cfg_paddr[3:2]))
        REG_LOCKOUT:   lockout_r <= cfg_pwdata[15:0];
        REG_WIDTH:     width_r   <= cfg_pwdata[6:0];
        REG_THRESHOLD: thresh_r  <= cfg_pwdata[SUM_W-1:0];
        REG_HOLDOFF:   holdoff_r <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(cfg_paddr[3:2]))
      REG_LOCKOUT:   cfg_prdata = 32'(lockout_r);
      REG_WIDTH:     cfg_prdata = 32'(width_r);
      REG_THRESHOLD: cfg_prdata = 32'(thresh_r);
      REG_HOLDOFF:   cfg_prdata = 32'(holdoff_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.lockout   = lockout_r;
  assign cfg.win_bins  = width_r;
  assign cfg.threshold = thresh_r;
  assign cfg.holdoff   = holdoff_r;

  hcwt_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  hcwt_back #(
    .NUM_SENSORS    (NUM_SENSORS),
    .MAX_PULSE_BINS (MAX_PULSE_BINS),
    .TIME_BITS      (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .clearing  (clearing),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.window_sum, res.trigger_bin};

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during sensor memory clear");

  a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(cmd_valid && cmd_ready))
    else $error("command issued during sensor memory clear");

  a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_tvalid)
    else $error("result pending during sensor memory clear");

  a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing) |-> in_tready)
    else $error("input not ready once the clear finished");

endmodule

FILE: tb/hcwt_checker.sv
// Scoreboard for the hit-count window trigger: snoops the register port and both streams,
// predicts trigger words from accepted input words and compares them in order.
// Depends on hcwt_pkg; also holds the small opcode package shared with tb_top.
`timescale 1ns / 1ps

package hcwt_tb_pkg;

  typedef enum bit {
    OP_HIT,
    OP_TICK
  } opcode_e;

endpackage

module hcwt_checker import hcwt_pkg::*; import hcwt_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  logic [31:0]        pulse_at [NUM_SENSORS_DEF];
  bit                 hit_seen [NUM_SENSORS_DEF];
  logic [COUNT_W-1:0] bin_count;
  logic [COUNT_W-1:0] bin_hist [MAX_PULSE_BINS_DEF];
  logic [31:0]        bin_idx;
  logic [31:0]        last_fire;
  bit                 fired;
  logic [15:0]        lockout;
  logic [6:0]         pwidth;
  logic [SUM_W-1:0]   threshold;
  logic [15:0]        holdoff;
  res_t               trigger_q [$];
  int                 errs = 0;

  function automatic void count_hit(logic [11:0] id, logic [31:0] t);
    if (hit_seen[id]) begin
      if (t <= pulse_at[id] || (t - pulse_at[id]) <= lockout) return;
    end
    hit_seen[id] = 1'b1;
    pulse_at[id] = t;
    if (bin_count != COUNT_MAX) bin_count++;
  endfunction

  function automatic void close_bin();
    int          w;
    int          k;
    logic [31:0] acc;
    res_t        want;
    w = (pwidth > MAX_PULSE_BINS_DEF) ? MAX_PULSE_BINS_DEF : int'(pwidth);
    for (k = MAX_PULSE_BINS_DEF - 1; k > 0; k--) bin_hist[k] = bin_hist[k-1];
    bin_hist[0] = bin_count;
    bin_count = '0;
    acc = '0;
    for (k = 0; k < w; k++) begin
      acc += bin_hist[k];
      if (acc > SUM_MAX) acc = SUM_MAX;
    end
    if (acc >= threshold && (!fired || (bin_idx - last_fire) > holdoff)) begin
      fired = 1'b1;
      last_fire = bin_idx;
      want.trigger_bin = bin_idx;
      want.window_sum = acc[SUM_W-1:0];
      trigger_q = {trigger_q, want};
    end
    bin_idx++;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      hit_seen = '{default: 1'b0};
      bin_hist = '{default: '0};
      bin_count = '0;
      bin_idx = '0;
      last_fire = '0;
      fired = 1'b0;
      lockout = '0;
      pwidth = 7'd1;
      threshold = SUM_W'(1);
      holdoff = '0;
      trigger_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_e'(cfg_paddr[3:2]))
          REG_LOCKOUT:   lockout = cfg_pwdata[15:0];
          REG_WIDTH:     pwidth = cfg_pwdata[6:0];
          REG_THRESHOLD: threshold = cfg_pwdata[SUM_W-1:0];
          REG_HOLDOFF:   holdoff = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (opcode_e'(in_tuser) == OP_TICK) close_bin();
        else count_hit(in_tdata[11:0], in_tdata[43:12]);
      end
      if (out_tvalid && out_tready) begin
        if (trigger_q.size() == 0) begin
          $display("%0t: trigger word with none expected: bin %0d sum %0d", $time,
                   out_tdata[31:0], out_tdata[53:32]);
          errs++;
        end else begin
          want = trigger_q.pop_front();
          if (out_tdata[31:0] !== want.trigger_bin) begin
            $display("%0t: trigger_bin expected %0d actual %0d", $time,
                     want.trigger_bin, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[53:32] !== want.window_sum) begin
            $display("%0t: window_sum expected %0d actual %0d (bin %0d)", $time,
                     want.window_sum, out_tdata[53:32], want.trigger_bin);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending <= trigger_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the hit-count window trigger testbench: clock, reset, register writes and stimulus.
// Instantiates hit_count_window_trigger_unit and hcwt_checker, and prints the verdict.
// Depends on hcwt_pkg and the opcode package in hcwt_checker.sv.
`timescale 1ns / 1ps

module tb_top;
  import hcwt_pkg::*;
  import hcwt_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  bit          choke = 1'b0;
  logic [31:0] tnow;

  hit_count_window_trigger_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  hcwt_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The sink stalls at random, and once holds off for a long stretch so the block backs up.
  initial begin : sink
    int hold_left = 0;
    bit choke_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke && !choke_done) begin
        hold_left = 400;
        choke_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  task automatic push_word(opcode_e op, logic [11:0] id, logic [31:0] t);
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'h0, t, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_e r, logic [31:0] v, int w);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 1);
    data = ($urandom() & ~mask) | (v & mask);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(int lock, int width, int thr, int hold);
    apb_write(REG_LOCKOUT, lock, 16);
    apb_write(REG_WIDTH, width, 7);
    apb_write(REG_THRESHOLD, thr, SUM_W);
    apb_write(REG_HOLDOFF, hold, 16);
  endtask

  // Mostly time-ordered hits on a small pool of sensors, mixed with ticks, with some stray ids and bad times.
  task automatic random_run(int n, int tick_pct, int step_max);
    int          k;
    int          r;
    opcode_e     op;
    logic [11:0] id;
    logic [31:0] t;
    for (k = 0; k < n; k++) begin
      op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_HIT;
      r = $urandom_range(99);
      if (r < 80) id = 12'($urandom_range(15));
      else if (r < 90) id = 12'($urandom());
      else id = (r < 95) ? 12'h000 : 12'hFFF;
      tnow += $urandom_range(step_max);
      r = $urandom_range(99);
      if (r < 90) t = tnow;
      else if (r < 96) t = tnow - $urandom_range(1, 40);
      else t = $urandom();
      push_word(op, id, t);
    end
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    tnow = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first hits, a repeated time, time going backwards, empty bins.
    push_word(OP_HIT, 12'h000, 32'h0000_0000);
    push_word(OP_HIT, 12'hFFF, 32'hFFFF_FFFF);
    push_word(OP_HIT, 12'h000, 32'h0000_0000);
    push_word(OP_HIT, 12'h000, 32'h0000_0001);
    push_word(OP_HIT, 12'h000, 32'h0000_0000);
    push_word(OP_TICK, 12'hABC, 32'h5555_AAAA);
    push_word(OP_TICK, 12'h000, 32'h0);
    push_word(OP_HIT, 12'hFFF, 32'hFFFF_FFFF);
    push_word(OP_TICK, 12'hFFF, 32'hFFFF_FFFF);
    settle();

    // Lockout edge and holdoff edge.
    program_regs(5, 3, 2, 1);
    push_word(OP_HIT, 12'h007, 32'd1000);
    push_word(OP_HIT, 12'h007, 32'd1005);
    push_word(OP_HIT, 12'h007, 32'd1006);
    push_word(OP_TICK, 12'h0, 32'h0);
    push_word(OP_TICK, 12'h0, 32'h0);
    push_word(OP_TICK, 12'h0, 32'h0);
    settle();

    // Zero width with zero threshold, then an oversized width with the top threshold.
    program_regs(0, 0, 0, 0);
    push_word(OP_HIT, 12'h010, 32'd50);
    push_word(OP_TICK, 12'h0, 32'h0);
    push_word(OP_TICK, 12'h0, 32'h0);
    settle();
    program_regs(0, 127, 4194303, 0);
    push_word(OP_HIT, 12'h011, 32'd60);
    push_word(OP_TICK, 12'h0, 32'h0);
    settle();

    program_regs(0, 1, 1, 0);
    random_run(55, 20, 3);
    settle();
    program_regs(20, 4, 6, 2);
    random_run(55, 20, 8);
    settle();
    program_regs(65535, 64, 3, 0);
    random_run(55, 20, 4000);
    settle();

    // Zero width fires on every bin; the sink chokes so the block fills up.
    program_regs(0, 0, 0, 0);
    choke <= 1'b1;
    random_run(60, 50, 5);
    settle();

    program_regs(3, 127, 10, 65535);
    random_run(55, 20, 6);
    settle();
    program_regs(10, 16, 4194303, 5);
    random_run(45, 20, 12);
    settle();
    program_regs($urandom_range(65535), $urandom_range(1, 64), $urandom_range(12),
                 $urandom_range(4));
    random_run(45, 20, $urandom_range(1, 30));
    settle();

    calm <= 1'b1;
    program_regs(8, 8, 12, 1);
    random_run(80, 20, 5);
    settle();
    calm <= 1'b0;

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hcwt_pkg.sv
rtl/hcwt_ram.sv
rtl/hcwt_fifo.sv
rtl/hcwt_front.sv
rtl/hcwt_back.sv
rtl/hit_count_window_trigger_unit.sv
tb/hcwt_checker.sv
tb/tb_top.sv
